// ----- rtl/core/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: request and
// response payloads, the microcode control word and the sequencer status.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W     = 48;
  localparam int TOTAL_W    = 13;
  localparam int INDEX_W    = 12;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int STEP_W     = 5;

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MARK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMSIZE = 2'd1;

  localparam logic [TOTAL_W-1:0] COUNT_MAX   = 13'h1FFF;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] length_bytes;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] frame_index;
    logic [ADDR_W-1:0]  frame_address;
    logic [TOTAL_W-1:0] used_count;
  } out_item_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_IS_ALLOC,
    C_IS_RESV,
    C_IS_MARK,
    C_CLR_MORE,
    C_FULL,
    C_SCAN_END,
    C_HIT,
    C_SPAN_DONE,
    C_MARK_BAD,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_ALLOC,
    WR_SPAN,
    WR_MARK
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ONE,
    CNT_SPAN
  } cnt_sel_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_SPAN
  } cur_sel_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_FAIL,
    RES_ALLOC,
    RES_OK
  } res_sel_e;

  typedef struct packed {
    cond_e    cond;
    step_t    target;
    logic     in_rdy;
    logic     ld_geom;
    logic     ld_end;
    logic     mem_rd;
    logic     emit;
    wr_sel_e  wr_sel;
    cnt_sel_e cnt_sel;
    cur_sel_e cur_sel;
    res_sel_e res_sel;
  } ctl_t;

  typedef struct packed {
    logic no_req;
    logic is_alloc;
    logic is_resv;
    logic is_mark;
    logic clr_more;
    logic full;
    logic scan_end;
    logic hit;
    logic span_done;
    logic mark_bad;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/core/bitmap_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit physical frame allocator over a bitmap of page frames.
// ----------------------------------------------------------------------------
// The bitmap sits in a single-port row memory of ROW_BITS frames per row, and
// a microcoded sequencer walks it one row at a time. An allocate request is
// refused when the used count has reached the frame limit; otherwise it reads
// rows from row zero until one holds a free frame or the scan reaches the
// limit. A reserve request reads and writes each row the range touches; a mark
// request reads and writes one row unless the address is refused, and an
// unused action is refused. One request is in work at a time, and the next
// request is accepted while the previous response still waits at the output;
// a response that stays stalled holds the request behind it before that
// request's response is emitted. After reset a clearing pass writes every row,
// during which no request is accepted; configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top #(
  parameter int MAX_FRAMES = 4096,
  parameter int ROW_BITS   = 64,
  parameter int PAGE_BYTES = 2097152
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bfa_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bfa_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bfa_pkg::*;

  localparam int NUM_ROWS = (MAX_FRAMES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  ctl_t                ctl;
  status_t             status;
  logic                mem_rd, mem_wr;
  logic [ROW_W-1:0]    mem_addr;
  logic [ROW_BITS-1:0] mem_wdata, mem_rdata;

  bfa_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  bfa_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .ROW_BITS   (ROW_BITS),
    .PAGE_BYTES (PAGE_BYTES),
    .ROW_W      (ROW_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_rd_o    (mem_rd),
    .mem_wr_o    (mem_wr),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  bfa_row_mem #(
    .ROWS  (NUM_ROWS),
    .WIDTH (ROW_BITS),
    .AW    (ROW_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rd_i    (mem_rd),
    .wr_i    (mem_wr),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- rtl/core/bfa_row_mem.sv -----
// ----------------------------------------------------------------------------
// bfa_row_mem
// Bitmap row store: one row written or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bfa_row_mem #(
  parameter int ROWS  = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             rd_i,
  input  logic             wr_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [ROWS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (rd_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bfa_sequencer.sv -----
// ----------------------------------------------------------------------------
// bfa_sequencer
// Microcode store and step counter. Each step issues one control word and
// either falls through or jumps when its selected condition holds.
// ----------------------------------------------------------------------------
module bfa_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bfa_pkg::status_t status_i,
  output bfa_pkg::ctl_t    ctl_o
);

  import bfa_pkg::*;

  localparam step_t S_CLR   = 5'd0;
  localparam step_t S_FETCH = 5'd1;
  localparam step_t S_DISP0 = 5'd2;
  localparam step_t S_DISP1 = 5'd3;
  localparam step_t S_DISP2 = 5'd4;
  localparam step_t S_FAIL  = 5'd5;
  localparam step_t S_WAIT  = 5'd6;
  localparam step_t S_EMIT  = 5'd7;
  localparam step_t S_A0    = 5'd8;
  localparam step_t S_A1    = 5'd9;
  localparam step_t S_A2    = 5'd10;
  localparam step_t S_A3    = 5'd11;
  localparam step_t S_A4    = 5'd12;
  localparam step_t S_R0    = 5'd13;
  localparam step_t S_R1    = 5'd14;
  localparam step_t S_OK    = 5'd15;
  localparam step_t S_M0    = 5'd16;
  localparam step_t S_M1    = 5'd17;
  localparam step_t S_M2    = 5'd18;

  function automatic ctl_t rom_word(step_t s);
    ctl_t w;
    w = '0;
    unique case (s)
      S_CLR: begin
        w.wr_sel  = WR_ZERO;
        w.cur_sel = CUR_ADV;
        w.cond    = C_CLR_MORE;
        w.target  = S_CLR;
      end
      S_FETCH: begin
        w.in_rdy = 1'b1;
        w.cond   = C_NO_REQ;
        w.target = S_FETCH;
      end
      S_DISP0: begin
        w.ld_geom = 1'b1;
        w.cond    = C_IS_ALLOC;
        w.target  = S_A0;
      end
      S_DISP1: begin
        w.ld_end = 1'b1;
        w.cond   = C_IS_RESV;
        w.target = S_R0;
      end
      S_DISP2: begin
        w.cond   = C_IS_MARK;
        w.target = S_M0;
      end
      S_FAIL: begin
        w.res_sel = RES_FAIL;
        w.cond    = C_ALWAYS;
        w.target  = S_WAIT;
      end
      S_WAIT: begin
        w.cond   = C_OUT_BUSY;
        w.target = S_WAIT;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_FETCH;
      end
      S_A0: begin
        w.cond   = C_FULL;
        w.target = S_FAIL;
      end
      S_A1: begin
        w.mem_rd = 1'b1;
        w.cond   = C_SCAN_END;
        w.target = S_FAIL;
      end
      S_A2: begin
        w.cond   = C_HIT;
        w.target = S_A4;
      end
      S_A3: begin
        w.cur_sel = CUR_ADV;
        w.cond    = C_ALWAYS;
        w.target  = S_A1;
      end
      S_A4: begin
        w.wr_sel  = WR_ALLOC;
        w.cnt_sel = CNT_ONE;
        w.res_sel = RES_ALLOC;
        w.cond    = C_ALWAYS;
        w.target  = S_WAIT;
      end
      S_R0: begin
        w.mem_rd = 1'b1;
        w.cond   = C_SPAN_DONE;
        w.target = S_OK;
      end
      S_R1: begin
        w.wr_sel  = WR_SPAN;
        w.cnt_sel = CNT_SPAN;
        w.cur_sel = CUR_SPAN;
        w.cond    = C_ALWAYS;
        w.target  = S_R0;
      end
      S_OK: begin
        w.res_sel = RES_OK;
        w.cond    = C_ALWAYS;
        w.target  = S_WAIT;
      end
      S_M0: begin
        w.cond   = C_MARK_BAD;
        w.target = S_FAIL;
      end
      S_M1: begin
        w.mem_rd = 1'b1;
      end
      S_M2: begin
        w.wr_sel  = WR_MARK;
        w.res_sel = RES_OK;
        w.cond    = C_ALWAYS;
        w.target  = S_WAIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_FETCH;
      end
    endcase
    return w;
  endfunction

  step_t pc_q, pc_d;
  ctl_t  ctl;
  logic  taken;

  assign ctl = rom_word(pc_q);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_REQ:    taken = status_i.no_req;
      C_IS_ALLOC:  taken = status_i.is_alloc;
      C_IS_RESV:   taken = status_i.is_resv;
      C_IS_MARK:   taken = status_i.is_mark;
      C_CLR_MORE:  taken = status_i.clr_more;
      C_FULL:      taken = status_i.full;
      C_SCAN_END:  taken = status_i.scan_end;
      C_HIT:       taken = status_i.hit;
      C_SPAN_DONE: taken = status_i.span_done;
      C_MARK_BAD:  taken = status_i.mark_bad;
      C_OUT_BUSY:  taken = status_i.out_busy;
      default:     taken = 1'b0;
    endcase
    pc_d = taken ? ctl.target : pc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_CLR;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o = ctl;

endmodule

// ----- rtl/core/bfa_datapath.sv -----
// ----------------------------------------------------------------------------
// bfa_datapath
// Request and configuration registers, frame cursor, row scan and span
// logic, used-frame counter and the response register.
// ----------------------------------------------------------------------------
module bfa_datapath #(
  parameter int MAX_FRAMES = 4096,
  parameter int ROW_BITS   = 64,
  parameter int PAGE_BYTES = 2097152,
  parameter int ROW_W      = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bfa_pkg::ctl_t                      ctl_i,
  output bfa_pkg::status_t                   status_o,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bfa_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bfa_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               mem_rd_o,
  output logic                               mem_wr_o,
  output logic [ROW_W-1:0]                   mem_addr_o,
  output logic [ROW_BITS-1:0]                mem_wdata_o,
  input  logic [ROW_BITS-1:0]                mem_rdata_i
);

  import bfa_pkg::*;

  localparam int NUM_ROWS = (MAX_FRAMES + ROW_BITS - 1) / ROW_BITS;
  localparam int RB_SH    = $clog2(ROW_BITS);
  localparam int CUR_W    = $clog2(NUM_ROWS * ROW_BITS + 1);
  localparam int PAGE_SH  = $clog2(PAGE_BYTES);
  localparam int FIRST_W  = ADDR_W - PAGE_SH;
  localparam int SUM_W    = (FIRST_W + 2 > CUR_W) ? FIRST_W + 2 : CUR_W;

  localparam logic [SUM_W-1:0] MAX_S   = SUM_W'(MAX_FRAMES);
  localparam logic [CUR_W-1:0] MAX_C   = CUR_W'(MAX_FRAMES);
  localparam logic [CUR_W-1:0] ROW_C   = CUR_W'(ROW_BITS);
  localparam logic [ROW_W-1:0] LAST_RW = ROW_W'(NUM_ROWS - 1);

  logic [ACT_W-1:0]   action_q;
  logic [ADDR_W-1:0]  addr_q, len_q;
  logic [TOTAL_W-1:0] total_q;
  logic [ADDR_W-1:0]  mem_bytes_q;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [CUR_W-1:0]   lim_q, end_q;
  logic [FIRST_W-1:0] first_q;
  logic [FIRST_W:0]   npg_q;
  logic               mark_bad_q;
  logic [TOTAL_W-1:0] count_q, count_d;
  logic               res_ok_q;
  logic [CUR_W-1:0]   res_frame_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic               in_acc;
  logic [FIRST_W-1:0] first_c;
  logic [FIRST_W:0]   npg_c;
  logic [SUM_W-1:0]   first_w, tot_w, end_sum;
  logic               first_ge;
  logic [CUR_W-1:0]   cur_init, lim_c, end_c;

  logic [CUR_W-1:0]    row_base, next_base, avail, hi, hi_off, span_full;
  logic [RB_SH-1:0]    col_lo, col_enc;
  logic [RB_SH:0]      hi_col, span_len;
  logic [ROW_BITS-1:0] vmask, free_bits, low1, span_mask, mark_bit;
  logic                hit;
  logic [TOTAL_W:0]    cnt_add, cnt_sum;
  logic [63:0]         fr_wide, fr_addr;

  assign in_acc      = in_valid_i && ctl_i.in_rdy;
  assign in_stall_o  = !ctl_i.in_rdy;
  assign cfg_ready_o = 1'b1;

  assign first_c  = addr_q[ADDR_W-1:PAGE_SH];
  assign npg_c    = {1'b0, len_q[ADDR_W-1:PAGE_SH]} + (FIRST_W + 1)'(|len_q[PAGE_SH-1:0]);
  assign first_w  = SUM_W'(first_c);
  assign tot_w    = SUM_W'(total_q);
  assign first_ge = first_w >= MAX_S;
  assign lim_c    = (tot_w < MAX_S) ? tot_w[CUR_W-1:0] : MAX_C;
  assign cur_init = (action_q == ACT_ALLOC) ? '0 : (first_ge ? MAX_C : first_w[CUR_W-1:0]);
  assign end_sum  = SUM_W'(first_q) + SUM_W'(npg_q);
  assign end_c    = (end_sum >= MAX_S) ? MAX_C : end_sum[CUR_W-1:0];

  assign row_base  = {cur_q[CUR_W-1:RB_SH], {RB_SH{1'b0}}};
  assign next_base = row_base + ROW_C;
  assign col_lo    = cur_q[RB_SH-1:0];

  assign avail     = lim_q - row_base;
  assign vmask     = (avail >= ROW_C) ? '1 : ~({ROW_BITS{1'b1}} << avail[RB_SH-1:0]);
  assign free_bits = ~mem_rdata_i & vmask;
  assign low1      = free_bits & (~free_bits + ROW_BITS'(1));
  assign hit       = |free_bits;

  always_comb begin
    col_enc = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (low1[i]) begin
        col_enc = col_enc | RB_SH'(i);
      end
    end
  end

  assign hi        = (end_q < next_base) ? end_q : next_base;
  assign hi_off    = hi - row_base;
  assign hi_col    = hi_off[RB_SH:0];
  assign span_full = hi - cur_q;
  assign span_len  = span_full[RB_SH:0];
  assign span_mask = ({ROW_BITS{1'b1}} << col_lo) & ~({ROW_BITS{1'b1}} << hi_col);
  assign mark_bit  = ROW_BITS'(1) << col_lo;

  always_comb begin
    status_o.no_req    = !in_valid_i;
    status_o.is_alloc  = action_q == ACT_ALLOC;
    status_o.is_resv   = action_q == ACT_RESERVE;
    status_o.is_mark   = action_q == ACT_MARK;
    status_o.clr_more  = mem_addr_o != LAST_RW;
    status_o.full      = count_q >= total_q;
    status_o.scan_end  = cur_q >= lim_q;
    status_o.hit       = hit;
    status_o.span_done = cur_q >= end_q;
    status_o.mark_bad  = mark_bad_q;
    status_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign mem_addr_o = cur_q[RB_SH +: ROW_W];
  assign mem_rd_o   = ctl_i.mem_rd;

  always_comb begin
    mem_wr_o    = 1'b1;
    mem_wdata_o = '0;
    unique case (ctl_i.wr_sel)
      WR_ZERO:  mem_wdata_o = '0;
      WR_ALLOC: mem_wdata_o = mem_rdata_i | low1;
      WR_SPAN:  mem_wdata_o = mem_rdata_i | span_mask;
      WR_MARK:  mem_wdata_o = mem_rdata_i | mark_bit;
      default:  mem_wr_o    = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl_i.cnt_sel)
      CNT_ONE:  cnt_add = (TOTAL_W + 1)'(1);
      CNT_SPAN: cnt_add = (TOTAL_W + 1)'(span_len);
      default:  cnt_add = '0;
    endcase
    cnt_sum = {1'b0, count_q} + cnt_add;
    count_d = cnt_sum[TOTAL_W] ? COUNT_MAX : cnt_sum[TOTAL_W-1:0];
  end

  always_comb begin
    unique case (ctl_i.cur_sel)
      CUR_ADV:  cur_d = next_base;
      CUR_SPAN: cur_d = hi;
      default:  cur_d = cur_q;
    endcase
    if (ctl_i.ld_geom) begin
      cur_d = cur_init;
    end
  end

  assign fr_wide = 64'(res_frame_q);
  assign fr_addr = fr_wide << PAGE_SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RESET;
      mem_bytes_q <= '0;
      cur_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TOTAL:   total_q     <= cfg_data_i[TOTAL_W-1:0];
          CFG_MEMSIZE: mem_bytes_q <= cfg_data_i[ADDR_W-1:0];
          default:     ;
        endcase
      end
      cur_q   <= cur_d;
      count_q <= count_d;
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= in_data_i.action;
      addr_q   <= in_data_i.byte_address;
      len_q    <= in_data_i.length_bytes;
    end
    if (ctl_i.ld_geom) begin
      first_q    <= first_c;
      npg_q      <= npg_c;
      lim_q      <= lim_c;
      mark_bad_q <= (addr_q >= mem_bytes_q) || first_ge;
    end
    if (ctl_i.ld_end) begin
      end_q <= end_c;
    end
    unique case (ctl_i.res_sel)
      RES_FAIL: begin
        res_ok_q    <= 1'b0;
        res_frame_q <= '0;
      end
      RES_ALLOC: begin
        res_ok_q    <= 1'b1;
        res_frame_q <= row_base | CUR_W'(col_enc);
      end
      RES_OK: begin
        res_ok_q    <= 1'b1;
        res_frame_q <= '0;
      end
      default: ;
    endcase
    if (ctl_i.emit) begin
      out_data_q.ok            <= res_ok_q;
      out_data_q.frame_index   <= fr_wide[INDEX_W-1:0];
      out_data_q.frame_address <= fr_addr[ADDR_W-1:0];
      out_data_q.used_count    <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/bfa_checker.sv -----
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the frame allocator: response holding, failure
// fields, count ordering and request/response balance.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bfa_pkg::out_item_t out_data_o
);

  import bfa_pkg::*;

  logic [1:0]         pend_q, pend_d;
  logic [TOTAL_W-1:0] last_q;
  logic               in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      last_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (out_acc) begin
        last_q <= out_data_o.used_count;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled response changed or was dropped.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |->
      out_data_o.frame_index == '0 && out_data_o.frame_address == '0)
    else $error("Failed response carries a frame.");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.used_count >= last_q)
    else $error("Used-frame count went down.");

  a_resp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("Response without an outstanding request.");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("Too many requests outstanding.");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_checker (.*);

// ----- verif/bitmap_frame_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top_tb
// Self-checking bench for the first-fit frame allocator. A directed table walks
// the corner cases of allocate, reserve and mark. Random request phases
// follow under several register settings. Typed table rows are checked against
// their expected entry, every other response against a bit-accurate model of
// the bitmap and the used-frame count; request gaps and response stalls are random.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top_tb;
  import bfa_pkg::*;

  localparam int MAX_FRAMES  = 4096;
  localparam int ROW_BITS    = 64;
  localparam int PAGE_BYTES  = 2097152;
  localparam int PAGE_SHIFT  = 21;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_CYCLES = 500;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN       = 250;

  localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MAX   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_sel;
    logic [CFG_DATA_W-1:0] cfg_val;
    in_item_t              req;
    logic                  typed;
    out_item_t             want;
  } directed_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [ROW_BITS-1:0] frame_rows [MAX_FRAMES/ROW_BITS];
  logic [TOTAL_W-1:0]  frames_used;
  logic [TOTAL_W-1:0]  limit_frames;
  logic [ADDR_W-1:0]   memory_size;

  out_item_t expected_frame_results [$];
  int        mismatches;
  int        responses_seen;
  int        tx_quiet;

  directed_row_t directed_plan [25] = '{
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, 48'd0, 48'd0}, 1'b1, '{1'b1, 12'd0, 48'd0, 13'd1}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, 48'd0, 48'd0}, 1'b1,
      '{1'b1, 12'd1, 48'h20_0000, 13'd2}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_MARK, 48'd0, 48'd0}, 1'b1, '{1'b0, 12'd0, 48'd0, 13'd2}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_UNUSED, ADDR_MAX, ADDR_MAX}, 1'b1,
      '{1'b0, 12'd0, 48'd0, 13'd2}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_RESERVE, 48'd0, 48'd0}, 1'b1,
      '{1'b1, 12'd0, 48'd0, 13'd2}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_RESERVE, 48'd0, 48'd1}, 1'b1,
      '{1'b1, 12'd0, 48'd0, 13'd3}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_RESERVE, ADDR_MAX, ADDR_MAX}, 1'b1,
      '{1'b1, 12'd0, 48'd0, 13'd3}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_RESERVE, 48'h60_0005, 48'h20_0001}, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, 48'd0, 48'd0}, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, ADDR_MAX, ADDR_MAX}, 1'b0, '0},
    '{1'b1, CFG_MEMSIZE, ADDR_MAX, '0, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_MARK, 48'hFFFF_FFFF_FFFE, 48'd0}, 1'b1,
      '{1'b0, 12'd0, 48'd0, 13'd7}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_MARK, 48'hC0_0000, 48'd0}, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_MARK, 48'hFF_FFFF, 48'd0}, 1'b0, '0},
    '{1'b1, CFG_TOTAL, 48'd8, '0, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, 48'd0, 48'd0}, 1'b1, '{1'b0, 12'd0, 48'd0, 13'd7}},
    '{1'b1, CFG_TOTAL, 48'd0, '0, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, 48'd0, 48'd0}, 1'b1, '{1'b0, 12'd0, 48'd0, 13'd7}},
    '{1'b1, CFG_TOTAL, 48'd4096, '0, 1'b0, '0},
    '{1'b1, CFG_MEMSIZE, 48'h2_0000_0000, '0, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_RESERVE, 48'h1_FFE0_0000, ADDR_MAX}, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, 48'd0, 48'd0}, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_MARK, 48'h2_0000_0000, 48'd0}, 1'b1,
      '{1'b0, 12'd0, 48'd0, 13'd9}},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_MARK, 48'h1_FFFF_FFFF, 48'd0}, 1'b0, '0},
    '{1'b0, CFG_TOTAL, 48'd0, '{ACT_ALLOC, ADDR_MAX, 48'd0}, 1'b0, '0}
  };

  bitmap_frame_allocator_top #(
    .MAX_FRAMES (MAX_FRAMES),
    .ROW_BITS   (ROW_BITS),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic void take_frame(logic [11:0] f);
    frame_rows[f[11:6]][f[5:0]] = 1'b1;
    if (frames_used != COUNT_MAX) frames_used++;
  endfunction

  function automatic out_item_t predict_frame_op(in_item_t req);
    out_item_t   res;
    logic [63:0] first;
    logic [63:0] pages;
    logic [63:0] stop;
    logic [63:0] f;
    res = '0;
    case (req.action)
      ACT_ALLOC: begin
        if (frames_used < limit_frames) begin
          stop = (limit_frames < MAX_FRAMES) ? 64'(limit_frames) : 64'(MAX_FRAMES);
          for (f = 0; f < stop; f++) begin
            if (!frame_rows[f[11:6]][f[5:0]]) begin
              take_frame(f[11:0]);
              res.ok = 1'b1;
              res.frame_index = f[11:0];
              res.frame_address = 48'(f << PAGE_SHIFT);
              break;
            end
          end
        end
      end
      ACT_RESERVE: begin
        first = 64'(req.byte_address >> PAGE_SHIFT);
        pages = 64'(req.length_bytes >> PAGE_SHIFT);
        if (req.length_bytes[PAGE_SHIFT-1:0] != '0) pages++;
        stop = first + pages;
        if (stop > MAX_FRAMES) stop = MAX_FRAMES;
        for (f = first; f < stop; f++) take_frame(f[11:0]);
        res.ok = 1'b1;
      end
      ACT_MARK: begin
        if (req.byte_address < memory_size) begin
          f = 64'(req.byte_address >> PAGE_SHIFT);
          if (f < MAX_FRAMES) begin
            frame_rows[f[11:6]][f[5:0]] = 1'b1;
            res.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.used_count = frames_used;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      tx_quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic in_item_t draw_request(bit wide_ranges);
    in_item_t    req;
    int          r;
    int unsigned pages;
    int unsigned frame;
    r = $urandom_range(0, 99);
    req.action = ACT_ALLOC;
    req.byte_address = rand48();
    req.length_bytes = rand48();
    if (r < 40) begin
      req.action = ACT_ALLOC;
    end else if (r < 70) begin
      req.action = ACT_RESERVE;
      frame = ($urandom_range(0, 9) == 0) ? $urandom_range(4080, 4095) : $urandom_range(0, 4095);
      req.byte_address = {15'd0, 12'(frame), 21'($urandom)};
      pages = wide_ranges ? $urandom_range(0, 4096) : $urandom_range(0, 3);
      req.length_bytes = 48'(pages) << PAGE_SHIFT;
      if ($urandom_range(0, 1) == 1) begin
        req.length_bytes = req.length_bytes | 48'($urandom_range(0, PAGE_BYTES - 1));
      end
    end else if (r < 85) begin
      req.action = ACT_MARK;
      r = $urandom_range(0, 3);
      if (r < 2) begin
        req.byte_address = {15'd0, 12'($urandom_range(0, 4095)), 21'($urandom)};
      end else if (r == 2 && memory_size != '0) begin
        req.byte_address = memory_size - 48'($urandom_range(0, 1));
      end
    end else if (r < 90) begin
      req.action = ACT_UNUSED;
    end else begin
      req.action = 2'($urandom);
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : response_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      responses_seen++;
      if (expected_frame_results.size() == 0) begin
        report_mismatch("unexpected response", '0, 64'(out_data_o));
      end else begin
        want = expected_frame_results.pop_front();
        if (out_data_o.ok !== want.ok)
          report_mismatch("ok", 64'(want.ok), 64'(out_data_o.ok));
        if (out_data_o.frame_index !== want.frame_index)
          report_mismatch("frame_index", 64'(want.frame_index), 64'(out_data_o.frame_index));
        if (out_data_o.frame_address !== want.frame_address)
          report_mismatch("frame_address", 64'(want.frame_address),
                          64'(out_data_o.frame_address));
        if (out_data_o.used_count !== want.used_count)
          report_mismatch("used_count", 64'(want.used_count), 64'(out_data_o.used_count));
      end
    end
  end

  initial begin : receiver
    int  stall_left;
    int  quiet_left;
    int  r;
    bit  held;
    stall_left = 0;
    quiet_left = 0;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!held && responses_seen >= 200) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          quiet_left = $urandom_range(20, 80);
          out_stall_i <= 1'b0;
        end else if (r < 70) begin
          out_stall_i <= 1'b0;
        end else if (r < 96) begin
          stall_left = $urandom_range(0, 3);
          out_stall_i <= 1'b1;
        end else begin
          stall_left = $urandom_range(10, 40);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[bitmap_frame_allocator_top] ERROR");
    $finish;
  end

  task automatic offer_request(in_item_t req, logic typed, out_item_t want);
    out_item_t got;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    got = predict_frame_op(req);
    expected_frame_results.push_back(typed ? want : got);
  endtask

  task automatic idle_sender();
    int n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_frame_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == CFG_TOTAL) limit_frames = val[TOTAL_W-1:0];
    else if (sel == CFG_MEMSIZE) memory_size = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] mem_setting;
    logic [CFG_DATA_W-1:0] total_setting;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    foreach (frame_rows[r]) frame_rows[r] = '0;
    frames_used  = '0;
    limit_frames = TOTAL_RESET;
    memory_size  = '0;
    mismatches = 0;
    responses_seen = 0;
    tx_quiet = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_cfg) begin
        write_reg(directed_plan[k].cfg_sel, directed_plan[k].cfg_val);
      end else begin
        offer_request(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].want);
        idle_sender();
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0, 3: mem_setting = {15'd0, 1'($urandom), $urandom};
        2: mem_setting = '0;
        default: mem_setting = ADDR_MAX;
      endcase
      total_setting = (ph == 1 || ph == 3) ? 48'($urandom_range(0, 4096)) : 48'(TOTAL_RESET);
      write_reg(CFG_TOTAL, total_setting);
      write_reg(CFG_MEMSIZE, mem_setting);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 120) settle();
        offer_request(draw_request(ph == 4), 1'b0, '0);
        idle_sender();
      end
    end

    settle();
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && expected_frame_results.size() == 0) begin
      $display("[bitmap_frame_allocator_top] OK");
    end else begin
      $display("[bitmap_frame_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
